// ===== rtl/core/lpsht_pkg.sv =====
// shared types and constants for the string hash table
package lpsht_pkg;
	localparam logic [2:0] ST_INSERTED  = 3'd0;
	localparam logic [2:0] ST_FOUND     = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_TOO_LONG  = 3'd4;
	localparam logic [31:0] HASH_BASE   = 32'd37;
	localparam logic [10:0] TABLE_SIZE_RESET = 11'd113;
	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND   = 1'b1;
endpackage

// ===== rtl/core/lpsht_ram.sv =====
// generic simple dual port ram (one write port, one read port) with registered read
module lpsht_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/lpsht_divider.sv =====
// restoring divider: 32-bit hash modulo the table size, one bit a cycle
module lpsht_divider #(
	parameter int SW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [31:0]   dividend,
	input  logic [SW-1:0] divisor,
	output logic          done,
	output logic [SW-1:0] remainder
);
	logic [31:0] quo_q;
	logic [SW:0] rem_q;
	logic [SW-1:0] div_q;
	logic [5:0] cnt_q;
	logic busy_q;
	logic [SW:0] trial;

	always_comb trial = {rem_q[SW-1:0], quo_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[30:0], 1'b0};
			if (trial >= {1'b0, div_q}) rem_q <= trial - {1'b0, div_q};
			else rem_q <= trial;
		end
	end

	assign remainder = rem_q[SW-1:0];
endmodule

// ===== rtl/core/linear_probe_string_hash_table.sv =====
// top level of the linear probing string hash table
// chars are taken one per cycle while busy is low; a last char starts the modulo, then
// each probed slot's length is read and checked, chars compared or written, then the strobe
// busy stays high from the last char of a key until its result strobe
// after reset the slot lengths are cleared, one slot a cycle, with busy high
// results are strobed for one cycle; the receiver cannot stall
module linear_probe_string_hash_table #(
	parameter int MAX_SLOTS     = 1024,
	parameter int MAX_KEY_CHARS = 22
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cmd,
	input  logic [7:0]  key_char,
	input  logic        key_last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data,
	output logic        done,
	output logic [2:0]  status,
	output logic [9:0]  slot_index
);
	localparam int SW  = $clog2(MAX_SLOTS);
	localparam int SZW = $clog2(MAX_SLOTS + 1);
	localparam int KW  = $clog2(MAX_KEY_CHARS + 1);
	localparam int CW  = $clog2(MAX_KEY_CHARS);
	localparam int CDEPTH = MAX_SLOTS * MAX_KEY_CHARS;
	localparam int AW  = $clog2(CDEPTH);

	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_RDLEN = 4'd3;
	localparam logic [3:0] S_CHKLEN = 4'd4;
	localparam logic [3:0] S_WRITE = 4'd5;
	localparam logic [3:0] S_CMP   = 4'd6;
	localparam logic [3:0] S_CMPW  = 4'd7;
	localparam logic [3:0] S_NEXT  = 4'd8;
	localparam logic [3:0] S_DONE  = 4'd9;

	logic [3:0] state_q;
	logic [10:0] table_size_q;
	logic [KW-1:0] key_count_q;
	logic [31:0] hash_q, power_q;
	logic [31:0] hash_next;
	logic overflow_q;
	logic cmd_q;
	logic [SW-1:0] pos_q, size_m1_q;
	logic [SZW-1:0] probes_q;
	logic [CW-1:0] ci_q;
	logic [2:0] status_q;
	logic [9:0] index_q;
	logic done_q;

	// key buffer
	logic [7:0] kbuf_q [MAX_KEY_CHARS];

	// length ram
	logic len_we;
	logic [SW-1:0] len_waddr, len_raddr;
	logic [4:0] len_wdata, len_rdata;
	// char ram
	logic ch_we;
	logic [AW-1:0] ch_waddr, ch_raddr;
	logic [7:0] ch_wdata, ch_rdata;

	lpsht_ram #(.WIDTH(5), .DEPTH(MAX_SLOTS)) u_len (
		.clk, .we(len_we), .waddr(len_waddr), .wdata(len_wdata),
		.raddr(len_raddr), .rdata(len_rdata)
	);
	lpsht_ram #(.WIDTH(8), .DEPTH(CDEPTH)) u_chars (
		.clk, .we(ch_we), .waddr(ch_waddr), .wdata(ch_wdata),
		.raddr(ch_raddr), .rdata(ch_rdata)
	);

	// hash including the char on the ports, so the modulo sees the final value
	assign hash_next = hash_q + {24'd0, key_char} * power_q;

	logic div_go, div_done;
	logic [SW:0] eff_size;
	logic [SW:0] div_rem;
	lpsht_divider #(.SW(SW + 1)) u_div (
		.clk, .arst_n, .go(div_go), .dividend(hash_next), .divisor(eff_size),
		.done(div_done), .remainder(div_rem)
	);

	always_comb begin
		if (table_size_q < 11'd2) eff_size = (SW + 1)'(2);
		else if ({21'd0, table_size_q} > 32'(MAX_SLOTS)) eff_size = (SW + 1)'(MAX_SLOTS);
		else eff_size = (SW + 1)'(table_size_q);
	end

	logic accept;
	logic [AW-1:0] slot_base;
	assign accept = start && !busy;
	assign busy = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign slot_base = AW'(pos_q * MAX_KEY_CHARS);
	assign div_go = accept && key_last && !(overflow_q ||
		(key_count_q == KW'(MAX_KEY_CHARS)));

	always_comb begin
		len_we    = 1'b0;
		len_waddr = pos_q;
		len_wdata = 5'(key_count_q);
		len_raddr = pos_q;
		ch_we     = 1'b0;
		ch_waddr  = slot_base + AW'(ci_q);
		ch_wdata  = kbuf_q[ci_q];
		ch_raddr  = slot_base + AW'(ci_q);
		unique case (state_q)
			S_CLEAR: begin
				len_we = 1'b1;
				len_wdata = '0;
			end
			S_WRITE: begin
				ch_we = 1'b1;
				len_we = (KW'(ci_q) == key_count_q - KW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			table_size_q <= lpsht_pkg::TABLE_SIZE_RESET;
			key_count_q <= '0;
			hash_q <= '0;
			power_q <= 32'd1;
			overflow_q <= 1'b0;
			pos_q <= '0;
			size_m1_q <= '0;
			probes_q <= '0;
			ci_q <= '0;
			status_q <= lpsht_pkg::ST_INSERTED;
			index_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) table_size_q <= cfg_data;
			unique case (state_q)
				S_CLEAR: begin
					pos_q <= pos_q + SW'(1);
					if (pos_q == SW'(MAX_SLOTS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						if (key_count_q < KW'(MAX_KEY_CHARS)) begin
							key_count_q <= key_count_q + KW'(1);
							hash_q <= hash_next;
							power_q <= power_q * lpsht_pkg::HASH_BASE;
						end else begin
							overflow_q <= 1'b1;
						end
						if (key_last) begin
							if (div_go) state_q <= S_DIV;
							else begin
								status_q <= lpsht_pkg::ST_TOO_LONG;
								index_q <= '0;
								state_q <= S_DONE;
							end
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						pos_q <= div_rem[SW-1:0];
						size_m1_q <= SW'(eff_size - (SW + 1)'(1));
						probes_q <= '0;
						state_q <= S_RDLEN;
					end
				end
				S_RDLEN: state_q <= S_CHKLEN;
				S_CHKLEN: begin
					ci_q <= '0;
					if (len_rdata == 5'd0) begin
						if (cmd_q == lpsht_pkg::CMD_INSERT) state_q <= S_WRITE;
						else begin
							status_q <= lpsht_pkg::ST_NOT_FOUND;
							index_q <= '0;
							state_q <= S_DONE;
						end
					end else if (cmd_q == lpsht_pkg::CMD_FIND &&
						KW'(len_rdata) == key_count_q) begin
						state_q <= S_CMP;
					end else state_q <= S_NEXT;
				end
				S_WRITE: begin
					ci_q <= ci_q + CW'(1);
					if (KW'(ci_q) == key_count_q - KW'(1)) begin
						status_q <= lpsht_pkg::ST_INSERTED;
						index_q <= 10'(pos_q);
						state_q <= S_DONE;
					end
				end
				S_CMP: state_q <= S_CMPW;
				S_CMPW: begin
					if (ch_rdata != kbuf_q[ci_q]) state_q <= S_NEXT;
					else if (KW'(ci_q) == key_count_q - KW'(1)) begin
						status_q <= lpsht_pkg::ST_FOUND;
						index_q <= 10'(pos_q);
						state_q <= S_DONE;
					end else begin
						ci_q <= ci_q + CW'(1);
						state_q <= S_CMP;
					end
				end
				S_NEXT: begin
					probes_q <= probes_q + SZW'(1);
					pos_q <= (pos_q == size_m1_q) ? '0 : pos_q + SW'(1);
					if (probes_q == SZW'(size_m1_q)) begin
						status_q <= (cmd_q == lpsht_pkg::CMD_INSERT) ?
							lpsht_pkg::ST_FULL : lpsht_pkg::ST_NOT_FOUND;
						index_q <= '0;
						state_q <= S_DONE;
					end else state_q <= S_RDLEN;
				end
				S_DONE: begin
					done_q <= 1'b1;
					key_count_q <= '0;
					hash_q <= '0;
					power_q <= 32'd1;
					overflow_q <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			if (key_count_q < KW'(MAX_KEY_CHARS)) kbuf_q[CW'(key_count_q)] <= key_char;
		end
	end

	assign done = done_q;
	assign status = status_q;
	assign slot_index = index_q;
endmodule

// ===== rtl/core/lpsht_checker.sv =====
// port level checks for the string hash table
module lpsht_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       key_last,
	input logic       done,
	input logic [2:0] status,
	input logic [9:0] slot_index
);
	a_done_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result beat longer than one cycle");
	a_last_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && key_last) |=> busy) else $error("busy not raised after key end");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("busy during result beat");
	a_status_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status <= lpsht_pkg::ST_TOO_LONG)) else $error("bad status");
	a_idx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status == lpsht_pkg::ST_NOT_FOUND || status == lpsht_pkg::ST_FULL ||
		status == lpsht_pkg::ST_TOO_LONG)) |-> slot_index == 10'd0)
		else $error("index not zero");
endmodule

bind linear_probe_string_hash_table lpsht_checker u_chk (
	.clk, .arst_n, .start, .busy, .key_last, .done, .status, .slot_index
);
